/* hdl/pgs_pkg.sv */
package pgs_pkg;

  localparam int DEF_NUM_CHANNELS = 16;

  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam int          DETECT_LSB   = 655;
  localparam logic [19:0] LOG2_500_Q16 = 20'd587582;
  localparam logic [17:0] LOG2_10_Q16  = 18'd217706;
  localparam logic [25:0] K_EXP_BASE   = 26'd479850;
  localparam logic [6:0]  INV_TIME_MIN = 7'd100;
  localparam logic [36:0] CV_HALF      = 37'd327680;
  localparam logic [19:0] RECIP10      = 20'd838861;

  localparam logic [2:0] CFG_TIME_KNOB    = 3'd0;
  localparam logic [2:0] CFG_CURVE_KNOB   = 3'd1;
  localparam logic [2:0] CFG_CHANCE_KNOB  = 3'd2;
  localparam logic [2:0] CFG_TIME_AMT     = 3'd3;
  localparam logic [2:0] CFG_CURVE_AMT    = 3'd4;
  localparam logic [2:0] CFG_CHANCE_AMT   = 3'd5;
  localparam logic [2:0] CFG_SAMPLE_PER   = 3'd6;

  localparam logic [15:0] RST_TIME_KNOB   = 16'd32768;
  localparam logic [15:0] RST_CURVE_KNOB  = 16'd32768;
  localparam logic [15:0] RST_CHANCE_KNOB = 16'd65535;
  localparam logic [31:0] RST_SAMPLE_PER  = 32'd89478;

  typedef logic [15:0][31:0] factor_tab_t;

  typedef struct packed {
    logic [20:0] held;
    logic [20:0] from;
    logic [20:0] to;
    logic [16:0] prog;
    logic        on;
    logic [20:0] prev;
  } rec_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_EFF_MUL, ST_EFF_RND, ST_EFF_QUO, ST_EFF_SUM, ST_DETECT, ST_BRANCH,
    ST_TIME_EXP, ST_SCALE, ST_POW_INIT, ST_POW_STEP, ST_POW_SHIFT, ST_INC_HI,
    ST_INC_LO, ST_INC_SUM, ST_K_EXP, ST_K_SET, ST_LOG_INIT, ST_LOG_STEP, ST_SH_EXP,
    ST_OUT_MUL, ST_OUT_RND, ST_STORE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_EFF_MUL, OP_EFF_RND, OP_EFF_QUO, OP_EFF_SUM, OP_DETECT,
    OP_TIME_EXP, OP_SCALE, OP_POW_INIT, OP_POW_STEP, OP_POW_SHIFT, OP_INC_HI,
    OP_INC_LO, OP_INC_SUM, OP_K_EXP, OP_K_SET, OP_LOG_INIT, OP_LOG_STEP, OP_SH_EXP,
    OP_OUT_MUL, OP_OUT_RND, OP_STORE
  } op_t;

  typedef enum logic [1:0] {
    USE_TIME, USE_K, USE_SHAPE
  } pow_use_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] idx;
  } cmd_t;

  typedef struct packed {
    logic glide;
  } stat_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] xv;
    logic [63:0] r;
    logic [63:0] b;
    xv = x;
    r  = '0;
    b  = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (b > xv) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != 0) begin
        if (xv >= r + b) begin
          xv = xv - (r + b);
          r  = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  function automatic factor_tab_t make_factors();
    factor_tab_t f;
    logic [63:0] t;
    t = 64'h8000_0000;
    for (int i = 0; i < 16; i++) begin
      t = isqrt64(t << 32);
      f[i] = t[31:0];
    end
    return f;
  endfunction

  localparam factor_tab_t FACTORS = make_factors();

endpackage

/* hdl/pgs_ctrl.sv */
module pgs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  pgs_pkg::stat_t stat,
  output pgs_pkg::cmd_t  cmd
);

  pgs_pkg::state_t   state_r, state_nxt;
  pgs_pkg::pow_use_t ret_r, ret_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pgs_pkg::ST_IDLE;
      ret_r       <= pgs_pkg::USE_TIME;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = pgs_pkg::OP_NONE;
    cmd.idx       = cnt_r;
    unique case (state_r)
      pgs_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = pgs_pkg::OP_LOAD;
          cnt_nxt   = '0;
          state_nxt = pgs_pkg::ST_EFF_MUL;
        end
      end
      pgs_pkg::ST_EFF_MUL: begin
        cmd.op    = pgs_pkg::OP_EFF_MUL;
        state_nxt = pgs_pkg::ST_EFF_RND;
      end
      pgs_pkg::ST_EFF_RND: begin
        cmd.op    = pgs_pkg::OP_EFF_RND;
        state_nxt = pgs_pkg::ST_EFF_QUO;
      end
      pgs_pkg::ST_EFF_QUO: begin
        cmd.op    = pgs_pkg::OP_EFF_QUO;
        state_nxt = pgs_pkg::ST_EFF_SUM;
      end
      pgs_pkg::ST_EFF_SUM: begin
        cmd.op = pgs_pkg::OP_EFF_SUM;
        if (cnt_r == 4'd2) begin
          cnt_nxt   = '0;
          state_nxt = pgs_pkg::ST_DETECT;
        end else begin
          cnt_nxt   = cnt_r + 4'd1;
          state_nxt = pgs_pkg::ST_EFF_MUL;
        end
      end
      pgs_pkg::ST_DETECT: begin
        cmd.op    = pgs_pkg::OP_DETECT;
        state_nxt = pgs_pkg::ST_BRANCH;
      end
      pgs_pkg::ST_BRANCH: begin
        state_nxt = stat.glide ? pgs_pkg::ST_TIME_EXP : pgs_pkg::ST_STORE;
      end
      pgs_pkg::ST_TIME_EXP: begin
        cmd.op    = pgs_pkg::OP_TIME_EXP;
        state_nxt = pgs_pkg::ST_SCALE;
      end
      pgs_pkg::ST_SCALE: begin
        cmd.op    = pgs_pkg::OP_SCALE;
        ret_nxt   = pgs_pkg::USE_TIME;
        state_nxt = pgs_pkg::ST_POW_INIT;
      end
      pgs_pkg::ST_POW_INIT: begin
        cmd.op    = pgs_pkg::OP_POW_INIT;
        cnt_nxt   = '0;
        state_nxt = pgs_pkg::ST_POW_STEP;
      end
      pgs_pkg::ST_POW_STEP: begin
        cmd.op  = pgs_pkg::OP_POW_STEP;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) state_nxt = pgs_pkg::ST_POW_SHIFT;
      end
      pgs_pkg::ST_POW_SHIFT: begin
        cmd.op = pgs_pkg::OP_POW_SHIFT;
        unique case (ret_r)
          pgs_pkg::USE_TIME: state_nxt = pgs_pkg::ST_INC_HI;
          pgs_pkg::USE_K:    state_nxt = pgs_pkg::ST_K_SET;
          default:           state_nxt = pgs_pkg::ST_OUT_MUL;
        endcase
      end
      pgs_pkg::ST_INC_HI: begin
        cmd.op    = pgs_pkg::OP_INC_HI;
        state_nxt = pgs_pkg::ST_INC_LO;
      end
      pgs_pkg::ST_INC_LO: begin
        cmd.op    = pgs_pkg::OP_INC_LO;
        state_nxt = pgs_pkg::ST_INC_SUM;
      end
      pgs_pkg::ST_INC_SUM: begin
        cmd.op    = pgs_pkg::OP_INC_SUM;
        state_nxt = pgs_pkg::ST_K_EXP;
      end
      pgs_pkg::ST_K_EXP: begin
        cmd.op    = pgs_pkg::OP_K_EXP;
        ret_nxt   = pgs_pkg::USE_K;
        state_nxt = pgs_pkg::ST_POW_INIT;
      end
      pgs_pkg::ST_K_SET: begin
        cmd.op    = pgs_pkg::OP_K_SET;
        state_nxt = pgs_pkg::ST_LOG_INIT;
      end
      pgs_pkg::ST_LOG_INIT: begin
        cmd.op    = pgs_pkg::OP_LOG_INIT;
        cnt_nxt   = '0;
        state_nxt = pgs_pkg::ST_LOG_STEP;
      end
      pgs_pkg::ST_LOG_STEP: begin
        cmd.op  = pgs_pkg::OP_LOG_STEP;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) state_nxt = pgs_pkg::ST_SH_EXP;
      end
      pgs_pkg::ST_SH_EXP: begin
        cmd.op    = pgs_pkg::OP_SH_EXP;
        ret_nxt   = pgs_pkg::USE_SHAPE;
        state_nxt = pgs_pkg::ST_POW_INIT;
      end
      pgs_pkg::ST_OUT_MUL: begin
        cmd.op    = pgs_pkg::OP_OUT_MUL;
        state_nxt = pgs_pkg::ST_OUT_RND;
      end
      pgs_pkg::ST_OUT_RND: begin
        cmd.op    = pgs_pkg::OP_OUT_RND;
        state_nxt = pgs_pkg::ST_STORE;
      end
      pgs_pkg::ST_STORE: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = pgs_pkg::OP_STORE;
          out_valid_nxt = 1'b1;
          state_nxt     = pgs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pgs_pkg::ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == pgs_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  a_out_from_store: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == pgs_pkg::ST_STORE)
    else $error("result raised outside store");

  a_eff_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pgs_pkg::ST_EFF_MUL) |-> (cnt_r <= 4'd2))
    else $error("control index out of range");

  a_pow_return: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pgs_pkg::ST_POW_SHIFT && ret_r == pgs_pkg::USE_K)
      |=> state_r == pgs_pkg::ST_K_SET)
    else $error("wrong return after exponent");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transfer taken while busy");

endmodule

/* hdl/pgs_datapath.sv */
module pgs_datapath #(
  parameter int NUM_CHANNELS = pgs_pkg::DEF_NUM_CHANNELS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pgs_pkg::cmd_t         cmd,
  output pgs_pkg::stat_t        stat,
  input  logic [3:0]            in_channel,
  input  logic signed [20:0]    in_pitch_in,
  input  logic signed [20:0]    in_time_cv,
  input  logic signed [20:0]    in_curve_cv,
  input  logic signed [20:0]    in_chance_cv,
  input  logic [15:0]           in_random_value,
  input  logic                  cfg_valid,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  output logic [3:0]            out_channel_out,
  output logic signed [20:0]    out_pitch_out,
  output logic                  out_glide_active
);

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [15:0] knob_r [3];
  logic [15:0] amt_r  [3];
  logic [31:0] sp_r;

  pgs_pkg::rec_t          mem_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] valid_r;
  pgs_pkg::rec_t          rd_r;
  logic                   rdv_r;
  pgs_pkg::rec_t          rec;

  logic [3:0]         ch_r;
  logic [20:0]        pitch_r;
  logic signed [20:0] cv_r [3];
  logic [15:0]        rnd_r;
  logic [16:0]        eff_r [3];
  logic signed [37:0] prod_r;
  logic [20:0]        x_r;
  logic               neg_r;
  logic [17:0]        quo_r;

  logic [20:0] held_r, from_r, to_r, res_r;
  logic [16:0] prog_r;
  logic        on_r, range_r;

  logic [25:0] e_r;
  logic [38:0] a_r;
  logic [32:0] pr_r;
  logic [32:0] pw_r;
  logic [55:0] m1_r;
  logic [54:0] m2_r;
  logic [20:0] k_r;
  logic [31:0] q_r;
  logic [15:0] frac_r;
  logic [4:0]  s_r;
  logic        lgz_r;
  logic signed [55:0] p2_r;

  logic [3:0]  out_ch_r;
  logic [20:0] out_pitch_r;
  logic        out_act_r;

  logic [1:0]         sel;
  logic signed [37:0] cvp;
  logic [37:0]        mag38;
  logic [36:0]        rsum;
  logic [40:0]        qprod;
  logic signed [19:0] ksum;
  logic [16:0]        eff_new;
  logic signed [21:0] dlt;
  logic               det, go, in_rng;
  logic [64:0]        pmul;
  logic [9:0]         pn;
  logic [56:0]        isum;
  logic [24:0]        inc;
  logic [16:0]        incs;
  logic [17:0]        psum;
  logic [17:0]        u;
  logic [35:0]        uk;
  logic [4:0]         sh;
  logic [16:0]        mnorm;
  logic [63:0]        sq64;
  logic [31:0]        sq;
  logic [20:0]        lg;
  logic [41:0]        klg;
  logic signed [21:0] diff;
  logic [32:0]        shp;
  logic [55:0]        mag56;
  logic [56:0]        osum;
  logic signed [25:0] adj;
  logic signed [25:0] rsum26;

  assign sel = cmd.idx[1:0];
  assign rec = rdv_r ? rd_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knob_r[0] <= pgs_pkg::RST_TIME_KNOB;
      knob_r[1] <= pgs_pkg::RST_CURVE_KNOB;
      knob_r[2] <= pgs_pkg::RST_CHANCE_KNOB;
      amt_r[0]  <= '0;
      amt_r[1]  <= '0;
      amt_r[2]  <= '0;
      sp_r      <= pgs_pkg::RST_SAMPLE_PER;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pgs_pkg::CFG_TIME_KNOB:   knob_r[0] <= cfg_data[15:0];
        pgs_pkg::CFG_CURVE_KNOB:  knob_r[1] <= cfg_data[15:0];
        pgs_pkg::CFG_CHANCE_KNOB: knob_r[2] <= cfg_data[15:0];
        pgs_pkg::CFG_TIME_AMT:    amt_r[0]  <= cfg_data[15:0];
        pgs_pkg::CFG_CURVE_AMT:   amt_r[1]  <= cfg_data[15:0];
        pgs_pkg::CFG_CHANCE_AMT:  amt_r[2]  <= cfg_data[15:0];
        pgs_pkg::CFG_SAMPLE_PER:  sp_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == pgs_pkg::OP_LOAD) begin
      rd_r <= mem_r[AW'(in_channel)];
    end
    if (cmd.op == pgs_pkg::OP_STORE && range_r) begin
      mem_r[AW'(ch_r)] <= '{held: held_r, from: from_r, to: to_r, prog: prog_r,
                            on: on_r, prev: res_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rdv_r   <= 1'b0;
    end else begin
      if (cmd.op == pgs_pkg::OP_LOAD) rdv_r <= valid_r[AW'(in_channel)];
      if (cmd.op == pgs_pkg::OP_STORE && range_r) valid_r[AW'(ch_r)] <= 1'b1;
    end
  end

  always_comb begin
    cvp   = cv_r[sel] * $signed({1'b0, amt_r[sel]});
    mag38 = prod_r[37] ? 38'(-prod_r) : 38'(prod_r);
    rsum  = mag38[36:0] + pgs_pkg::CV_HALF;
    qprod = 41'(x_r) * 41'(pgs_pkg::RECIP10);
    ksum  = $signed({4'd0, knob_r[sel]}) +
            (neg_r ? -$signed({2'd0, quo_r}) : $signed({2'd0, quo_r}));
    if (ksum < 0) begin
      eff_new = '0;
    end else if (ksum > $signed({3'd0, pgs_pkg::ONE_Q16})) begin
      eff_new = pgs_pkg::ONE_Q16;
    end else begin
      eff_new = ksum[16:0];
    end

    dlt    = $signed({pitch_r[20], pitch_r}) - $signed({rec.held[20], rec.held});
    det    = (dlt > 22'(pgs_pkg::DETECT_LSB)) || (dlt < -22'(pgs_pkg::DETECT_LSB));
    go     = ({1'b0, rnd_r} < eff_r[2]);
    in_rng = ({28'd0, ch_r} < NUM_CHANNELS);

    pmul = 65'(pr_r) * 65'(pgs_pkg::FACTORS[cmd.idx]);
    pn   = e_r[25:16];

    isum = 57'(m1_r) + 57'(m2_r[54:16]);
    inc  = isum[56:32];
    incs = (inc > 25'(pgs_pkg::ONE_Q16)) ? pgs_pkg::ONE_Q16 : inc[16:0];
    psum = {1'b0, prog_r} + {1'b0, incs};

    u  = 18'd131072 - {eff_r[1], 1'b0};
    uk = 36'(u) * 36'(pgs_pkg::LOG2_10_Q16);

    sh = 5'd16;
    for (int i = 0; i < 16; i++) begin
      if (prog_r[i]) sh = 5'(16 - i);
    end
    mnorm = 17'({1'b0, prog_r[15:0]} << sh);

    sq64 = 64'(q_r) * 64'(q_r);
    sq   = sq64[61:30];

    lg  = lgz_r ? '0 : ({s_r, 16'd0} - {5'd0, frac_r});
    klg = 42'(k_r) * 42'(lg);

    diff   = $signed({to_r[20], to_r}) - $signed({from_r[20], from_r});
    shp    = (prog_r == '0) ? '0 : pw_r;
    mag56  = p2_r[55] ? 56'(-p2_r) : 56'(p2_r);
    osum   = 57'(mag56) + 57'(33'h0_8000_0000);
    adj    = p2_r[55] ? -$signed({1'b0, osum[56:32]}) : $signed({1'b0, osum[56:32]});
    rsum26 = $signed({{5{from_r[20]}}, from_r}) + adj;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      pgs_pkg::OP_LOAD: begin
        ch_r    <= in_channel;
        pitch_r <= in_pitch_in;
        cv_r[0] <= in_time_cv;
        cv_r[1] <= in_curve_cv;
        cv_r[2] <= in_chance_cv;
        rnd_r   <= in_random_value;
      end
      pgs_pkg::OP_EFF_MUL: prod_r <= cvp;
      pgs_pkg::OP_EFF_RND: begin
        x_r   <= rsum[36:16];
        neg_r <= prod_r[37];
      end
      pgs_pkg::OP_EFF_QUO: quo_r <= qprod[40:23];
      pgs_pkg::OP_EFF_SUM: eff_r[sel] <= eff_new;
      pgs_pkg::OP_DETECT: begin
        range_r <= in_rng;
        held_r  <= det ? pitch_r : rec.held;
        from_r  <= (det && go) ? rec.prev : rec.from;
        to_r    <= (det && go) ? pitch_r : rec.to;
        prog_r  <= (det && go) ? '0 : rec.prog;
        on_r    <= in_rng && (det ? go : rec.on);
        res_r   <= pitch_r;
      end
      pgs_pkg::OP_TIME_EXP: e_r <= 26'((37'(eff_r[0]) * 37'(pgs_pkg::LOG2_500_Q16)) >> 16);
      pgs_pkg::OP_SCALE: a_r <= 39'(sp_r) * 39'(pgs_pkg::INV_TIME_MIN);
      pgs_pkg::OP_POW_INIT: pr_r <= 33'h1_0000_0000;
      pgs_pkg::OP_POW_STEP: begin
        if (e_r[4'd15 - cmd.idx]) pr_r <= pmul[64:32];
      end
      pgs_pkg::OP_POW_SHIFT: pw_r <= (pn > 10'd32) ? '0 : (pr_r >> pn[5:0]);
      pgs_pkg::OP_INC_HI: m1_r <= 56'(a_r) * 56'(pw_r[32:16]);
      pgs_pkg::OP_INC_LO: m2_r <= 55'(a_r) * 55'(pw_r[15:0]);
      pgs_pkg::OP_INC_SUM: begin
        prog_r <= (psum > 18'(pgs_pkg::ONE_Q16)) ? pgs_pkg::ONE_Q16 : psum[16:0];
      end
      pgs_pkg::OP_K_EXP: e_r <= pgs_pkg::K_EXP_BASE - 26'(uk[35:16]);
      pgs_pkg::OP_K_SET: k_r <= pw_r[32:12];
      pgs_pkg::OP_LOG_INIT: begin
        lgz_r  <= prog_r[16];
        s_r    <= sh;
        q_r    <= {1'b0, mnorm, 14'd0};
        frac_r <= '0;
      end
      pgs_pkg::OP_LOG_STEP: begin
        frac_r <= {frac_r[14:0], sq[31]};
        q_r    <= sq[31] ? (sq >> 1) : sq;
      end
      pgs_pkg::OP_SH_EXP: e_r <= klg[41:16];
      pgs_pkg::OP_OUT_MUL: p2_r <= diff * $signed({1'b0, shp});
      pgs_pkg::OP_OUT_RND: begin
        res_r <= rsum26[20:0];
        if (prog_r[16]) on_r <= 1'b0;
      end
      pgs_pkg::OP_STORE: begin
        out_ch_r    <= ch_r;
        out_pitch_r <= res_r;
        out_act_r   <= on_r;
      end
      default: ;
    endcase
  end

  assign stat.glide       = on_r;
  assign out_channel_out  = out_ch_r;
  assign out_pitch_out    = $signed(out_pitch_r);
  assign out_glide_active = out_act_r;

endmodule

/* hdl/pitch_glide_shaper.sv */
// Per-channel pitch glider with shaped curve and glide chance. One item is
// taken at a time; the result comes sooner when the channel is not gliding,
// as the glide steps are then skipped. The next transfer can be taken in the
// same cycle as the result appears. A result still waiting at the output
// holds the store step. The glide path is set by the shared 2^-x iterator
// (16 multiply steps, run three times per gliding item) and the 16-step log2
// squaring loop. Channel state lives in a per-channel record memory with one
// valid bit per channel; there is no clearing pass after reset. Configuration
// may be written at any time the block is idle.
module pitch_glide_shaper #(
  parameter int NUM_CHANNELS = pgs_pkg::DEF_NUM_CHANNELS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_channel,
  input  logic signed [20:0] in_pitch_in,
  input  logic signed [20:0] in_time_cv,
  input  logic signed [20:0] in_curve_cv,
  input  logic signed [20:0] in_chance_cv,
  input  logic [15:0]        in_random_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_channel_out,
  output logic signed [20:0] out_pitch_out,
  output logic               out_glide_active,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  pgs_pkg::cmd_t  cmd;
  pgs_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  pgs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pgs_datapath #(.NUM_CHANNELS(NUM_CHANNELS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_channel       (in_channel),
    .in_pitch_in      (in_pitch_in),
    .in_time_cv       (in_time_cv),
    .in_curve_cv      (in_curve_cv),
    .in_chance_cv     (in_chance_cv),
    .in_random_value  (in_random_value),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_channel_out  (out_channel_out),
    .out_pitch_out    (out_pitch_out),
    .out_glide_active (out_glide_active)
  );

endmodule
